FILE: rtl/rank_sort_engine_top_assert.svh
// assertion macros shared by the rank sort engine modules
// expects clk and rst_n in the scope of each use
`ifndef RANK_SORT_ENGINE_TOP_ASSERT_SVH
`define RANK_SORT_ENGINE_TOP_ASSERT_SVH

// condition must hold at every clock edge out of reset
`define RSE_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("rank sort engine: invariant violated");

// consequence must hold in the cycle after the trigger
`define RSE_ASSERT_NEXT(label, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("rank sort engine: sequence violated");

`endif

FILE: rtl/rse_pkg.sv
// shared types and defaults for the rank sort engine
// no dependencies
`timescale 1ns / 1ps

package rse_pkg;

    // default store depth
    localparam int MAX_ITEMS_DEF = 16;

    // value width, signed q16.16
    localparam int VALUE_W = 32;

    // sequencer states
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_RANK,
        ST_FLUSH,
        ST_EMIT_RD,
        ST_EMIT_WAIT
    } rse_state_t;

    // one compare issued to the rank unit
    typedef struct packed {
        logic issue;
        logic first;
        logic last;
    } rank_ctl_t;

    // one read of the sorted store toward the output register
    typedef struct packed {
        logic rd;
        logic last;
    } emit_ctl_t;

endpackage

FILE: rtl/rse_rank_unit.sv
// shared comparator and rank accumulator of the rank sort engine
// depends on rse_pkg
`timescale 1ns / 1ps

module rse_rank_unit #(
    parameter int MAX_ITEMS = rse_pkg::MAX_ITEMS_DEF,
    localparam int IDX_W = $clog2(MAX_ITEMS)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rse_pkg::rank_ctl_t          ctl,
    input  logic [IDX_W-1:0]            idx_i,
    input  logic [IDX_W-1:0]            idx_j,
    input  logic [rse_pkg::VALUE_W-1:0] value_i,
    input  logic [rse_pkg::VALUE_W-1:0] value_j,
    output logic                        wr_en,
    output logic [IDX_W-1:0]            wr_addr,
    output logic [rse_pkg::VALUE_W-1:0] wr_data
);

    rse_pkg::rank_ctl_t ctl_d_reg;
    logic [IDX_W-1:0]   idx_i_d_reg;
    logic [IDX_W-1:0]   idx_j_d_reg;
    logic [IDX_W-1:0]   acc_reg;
    logic [IDX_W-1:0]   acc_next;
    logic               less;

    // align control with the registered store reads
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_d_reg <= '0;
        end
        else
        begin
            ctl_d_reg <= ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_i_d_reg <= idx_i;
        idx_j_d_reg <= idx_j;
    end

    // value j ranks below value i; ties go by load order
    always_comb
    begin
        less = ($signed(value_j) < $signed(value_i)) ||
               ((value_j == value_i) && (idx_j_d_reg < idx_i_d_reg));
        if (ctl_d_reg.first)
        begin
            acc_next = IDX_W'(less);
        end
        else
        begin
            acc_next = acc_reg + IDX_W'(less);
        end
    end

    // running count of smaller values
    always_ff @(posedge clk)
    begin
        if (ctl_d_reg.issue)
        begin
            acc_reg <= acc_next;
        end
    end

    // place value i at its rank after its last compare
    assign wr_en   = ctl_d_reg.issue && ctl_d_reg.last;
    assign wr_addr = acc_next;
    assign wr_data = value_i;

endmodule

FILE: rtl/rse_ctrl.sv
// sequencer of the rank sort engine: load, rank sweep, emit
// depends on rse_pkg and rank_sort_engine_top_assert.svh
`timescale 1ns / 1ps

`include "rank_sort_engine_top_assert.svh"

module rse_ctrl #(
    parameter int MAX_ITEMS = rse_pkg::MAX_ITEMS_DEF,
    localparam int IDX_W = $clog2(MAX_ITEMS),
    localparam int CNT_W = $clog2(MAX_ITEMS + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               is_final,
    output logic               in_ready,
    input  logic               out_ready,
    output logic               out_valid,
    output logic               load_we,
    output logic [IDX_W-1:0]   load_addr,
    output rse_pkg::rank_ctl_t rank_ctl,
    output logic [IDX_W-1:0]   rank_i,
    output logic [IDX_W-1:0]   rank_j,
    output rse_pkg::emit_ctl_t emit_ctl,
    output logic [IDX_W-1:0]   emit_addr
);

    rse_pkg::rse_state_t state_reg;
    rse_pkg::rse_state_t state_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [IDX_W-1:0]    i_reg;
    logic [IDX_W-1:0]    i_next;
    logic [IDX_W-1:0]    j_reg;
    logic [IDX_W-1:0]    j_next;
    logic [IDX_W-1:0]    k_reg;
    logic [IDX_W-1:0]    k_next;
    logic [CNT_W-1:0]    count_less;
    logic [IDX_W-1:0]    last_idx;
    logic                in_xfer;
    logic                out_xfer;
    logic                has_room;
    logic                j_last;
    logic                i_last;
    logic                k_last;

    // shared decodes
    always_comb
    begin
        count_less = count_reg - CNT_W'(1);
        last_idx   = count_less[IDX_W-1:0];
        has_room   = count_reg < CNT_W'(MAX_ITEMS);
        j_last     = j_reg == last_idx;
        i_last     = i_reg == last_idx;
        k_last     = k_reg == last_idx;
        in_xfer    = in_valid && (state_reg == rse_pkg::ST_LOAD);
        out_xfer   = out_ready && (state_reg == rse_pkg::ST_EMIT_WAIT);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rse_pkg::ST_LOAD:
            begin
                if (in_xfer && is_final)
                begin
                    state_next = rse_pkg::ST_RANK;
                end
            end
            rse_pkg::ST_RANK:
            begin
                if (j_last && i_last)
                begin
                    state_next = rse_pkg::ST_FLUSH;
                end
            end
            rse_pkg::ST_FLUSH:
            begin
                state_next = rse_pkg::ST_EMIT_RD;
            end
            rse_pkg::ST_EMIT_RD:
            begin
                state_next = rse_pkg::ST_EMIT_WAIT;
            end
            rse_pkg::ST_EMIT_WAIT:
            begin
                if (out_xfer)
                begin
                    state_next = k_last ? rse_pkg::ST_LOAD : rse_pkg::ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = rse_pkg::ST_LOAD;
            end
        endcase
    end

    // counter updates
    always_comb
    begin
        count_next = count_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        case (state_reg)
            rse_pkg::ST_LOAD:
            begin
                if (in_xfer && has_room)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                i_next = '0;
                j_next = '0;
            end
            rse_pkg::ST_RANK:
            begin
                j_next = j_last ? '0 : j_reg + IDX_W'(1);
                if (j_last)
                begin
                    i_next = i_reg + IDX_W'(1);
                end
                k_next = '0;
            end
            rse_pkg::ST_EMIT_WAIT:
            begin
                if (out_xfer)
                begin
                    k_next = k_reg + IDX_W'(1);
                    if (k_last)
                    begin
                        count_next = '0;
                    end
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rse_pkg::ST_LOAD;
            count_reg <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    // outputs
    always_comb
    begin
        in_ready       = state_reg == rse_pkg::ST_LOAD;
        out_valid      = state_reg == rse_pkg::ST_EMIT_WAIT;
        load_we        = in_xfer && has_room;
        load_addr      = count_reg[IDX_W-1:0];
        rank_ctl.issue = state_reg == rse_pkg::ST_RANK;
        rank_ctl.first = j_reg == '0;
        rank_ctl.last  = j_last;
        rank_i         = i_reg;
        rank_j         = j_reg;
        emit_ctl.rd    = state_reg == rse_pkg::ST_EMIT_RD;
        emit_ctl.last  = k_last;
        emit_addr      = k_reg;
    end

    // the store count never exceeds the depth
    `RSE_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(MAX_ITEMS))
    // a rank sweep only runs on a non-empty set
    `RSE_ASSERT_ALWAYS(a_rank_nonempty, (state_reg != rse_pkg::ST_RANK) || (count_reg != '0))
    // the last result returns the block to loading with an empty store
    `RSE_ASSERT_NEXT(a_run_done, out_xfer && k_last, in_ready && (count_reg == '0))

endmodule

FILE: rtl/rank_sort_engine_top.sv
// top level of the rank sort engine: load and sorted stores, sequencer, rank unit
// depends on rse_pkg, rse_ctrl, rse_rank_unit and rank_sort_engine_top_assert.svh
`timescale 1ns / 1ps
//
// usage
//   input channel (in_valid/in_ready) carries sample_value and is_final; each
//   transfer loads one signed q16.16 value, up to MAX_ITEMS, further loads are
//   dropped. a transfer with is_final set starts the sort of the held set.
//   output channel (out_valid/out_ready) returns the set in ascending order,
//   equal values in load order, with end_of_run set on the last result.
//   after the final transfer one shared comparator compares one pair per
//   cycle over every ordered pair of the n held values, fed by a two-port
//   read of the load store. each result is then read from the sorted store
//   into the output register and presented until it is taken. in_ready is
//   low from the final transfer until the last result is taken; a stalled
//   receiver holds the output register and the sequencer. reset empties the
//   load store and returns to loading; store contents need no clearing.
//

`include "rank_sort_engine_top_assert.svh"

module rank_sort_engine_top #(
    parameter int MAX_ITEMS = rse_pkg::MAX_ITEMS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [rse_pkg::VALUE_W-1:0] sample_value,
    input  logic                               is_final,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [rse_pkg::VALUE_W-1:0] sorted_value,
    output logic                               end_of_run
);

    localparam int IDX_W = $clog2(MAX_ITEMS);

    logic [rse_pkg::VALUE_W-1:0] load_mem [MAX_ITEMS];
    logic [rse_pkg::VALUE_W-1:0] sorted_mem [MAX_ITEMS];
    logic [rse_pkg::VALUE_W-1:0] rd_i_reg;
    logic [rse_pkg::VALUE_W-1:0] rd_j_reg;
    logic [rse_pkg::VALUE_W-1:0] out_value_reg;
    logic                        out_last_reg;
    logic                        load_we;
    logic [IDX_W-1:0]            load_addr;
    rse_pkg::rank_ctl_t          rank_ctl;
    logic [IDX_W-1:0]            rank_i;
    logic [IDX_W-1:0]            rank_j;
    rse_pkg::emit_ctl_t          emit_ctl;
    logic [IDX_W-1:0]            emit_addr;
    logic                        sort_we;
    logic [IDX_W-1:0]            sort_addr;
    logic [rse_pkg::VALUE_W-1:0] sort_data;

    // sequencer
    rse_ctrl #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .is_final  (is_final),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .load_we   (load_we),
        .load_addr (load_addr),
        .rank_ctl  (rank_ctl),
        .rank_i    (rank_i),
        .rank_j    (rank_j),
        .emit_ctl  (emit_ctl),
        .emit_addr (emit_addr)
    );

    // load store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            load_mem[load_addr] <= sample_value;
        end
        rd_i_reg <= load_mem[rank_i];
        rd_j_reg <= load_mem[rank_j];
    end

    // shared comparator and rank count
    rse_rank_unit #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_rank (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (rank_ctl),
        .idx_i   (rank_i),
        .idx_j   (rank_j),
        .value_i (rd_i_reg),
        .value_j (rd_j_reg),
        .wr_en   (sort_we),
        .wr_addr (sort_addr),
        .wr_data (sort_data)
    );

    // sorted store; its read register is the output register
    always_ff @(posedge clk)
    begin
        if (sort_we)
        begin
            sorted_mem[sort_addr] <= sort_data;
        end
        if (emit_ctl.rd)
        begin
            out_value_reg <= sorted_mem[emit_addr];
            out_last_reg  <= emit_ctl.last;
        end
    end

    assign sorted_value = $signed(out_value_reg);
    assign end_of_run   = out_last_reg;

    // loading and emitting never overlap
    `RSE_ASSERT_ALWAYS(a_one_side, !(in_ready && out_valid))
    // a final transfer closes the input side and starts the sweep
    `RSE_ASSERT_NEXT(a_final_starts, in_valid && in_ready && is_final, !in_ready && !out_valid)
    // no sorted store write while results are being emitted
    `RSE_ASSERT_ALWAYS(a_no_late_write, !(sort_we && (out_valid || emit_ctl.rd)))

endmodule

FILE: tb/sv/rank_sort_engine_top_tb.sv
// testbench for rank_sort_engine_top: loads value sets, predicts the ascending order
// depends on rse_pkg and rank_sort_engine_top
`timescale 1ns / 1ps

module rank_sort_engine_top_tb;

    localparam int STORE_DEPTH    = rse_pkg::MAX_ITEMS_DEF;
    localparam int VW             = rse_pkg::VALUE_W;
    localparam int TIMEOUT_CYCLES = 1_000_000;
    localparam int SETTLE_CYCLES  = 40;

    // one expected result: value and end-of-run flag
    typedef struct packed {
        logic signed [VW-1:0] value;
        logic                 last;
    } sorted_rec_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic signed [VW-1:0] sample_value;
    logic                 is_final;
    logic                 out_valid;
    logic                 out_ready;
    logic signed [VW-1:0] sorted_value;
    logic                 end_of_run;

    // predictor state and scoreboard
    logic signed [VW-1:0] held_values[$];
    sorted_rec_t          sorted_expect[$];

    int  fail_count     = 0;
    int  transfers_in   = 0;
    int  sets_sorted    = 0;
    int  results_seen   = 0;
    bit  quiet          = 1'b0;
    bit  valid_up       = 1'b0;

    rank_sort_engine_top #(
        .MAX_ITEMS(STORE_DEPTH)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .sample_value(sample_value),
        .is_final    (is_final),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .sorted_value(sorted_value),
        .end_of_run  (end_of_run)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // watchdog
    initial
    begin
        repeat (TIMEOUT_CYCLES) @(posedge clk);
        $display("RESULT: ERROR");
        $finish;
    end

    // idle length: mostly none or short, sometimes long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet)
            return 0;
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // hold v if the store has room; on a final value rank each held value, place it, and queue the ascending run
    function automatic void rank_and_queue(logic signed [VW-1:0] v, logic fin);
        logic signed [VW-1:0] placed[STORE_DEPTH];
        sorted_rec_t          rec;
        int                   n;
        int                   rank;
        if (held_values.size() < STORE_DEPTH)
            held_values.push_back(v);
        if (!fin)
            return;
        n = held_values.size();
        for (int i = 0; i < n; i++)
        begin
            rank = 0;
            for (int j = 0; j < n; j++)
            begin
                // ties resolved by load order
                if (held_values[j] < held_values[i] ||
                    (held_values[j] == held_values[i] && j < i))
                    rank++;
            end
            placed[rank] = held_values[i];
        end
        for (int i = 0; i < n; i++)
        begin
            rec.value = placed[i];
            rec.last  = (i == n - 1);
            sorted_expect.push_back(rec);
        end
        held_values.delete();
        sets_sorted++;
    endfunction

    // send one value; valid stays up after the transfer until the next call decides
    task automatic send_value(input logic signed [VW-1:0] v, input logic fin);
        int gap;
        gap = pick_gap();
        if (gap > 0 && valid_up)
        begin
            in_valid <= 1'b0;
            valid_up = 1'b0;
        end
        repeat (gap) @(posedge clk);
        in_valid     <= 1'b1;
        sample_value <= v;
        is_final     <= fin;
        valid_up = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        rank_and_queue(v, fin);
        transfers_in++;
    endtask

    // sender stops and waits for every queued result
    task automatic wait_drained();
        if (valid_up)
        begin
            in_valid <= 1'b0;
            valid_up = 1'b0;
        end
        while (sorted_expect.size() != 0)
            @(posedge clk);
    endtask

    // random value in one of several flavors
    function automatic logic signed [VW-1:0] rand_value(int flavor);
        logic signed [VW-1:0] corners[8];
        int                   k;
        corners = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                    32'h0000_0001, 32'h8000_0001, 32'h7FFF_FFFE, 32'h0001_0000};
        case (flavor)
            0: return $urandom;
            // few distinct integers, lots of ties
            1:
            begin
                k = $urandom_range(0, 6);
                k = k - 3;
                return k <<< 16;
            end
            2: return corners[$urandom_range(0, 7)];
            default:
            begin
                if ($urandom_range(0, 1) == 0)
                    return $urandom;
                return corners[$urandom_range(0, 7)];
            end
        endcase
    endfunction

    // receiver: random stalls, checks every result transfer
    initial
    begin
        sorted_rec_t want;
        int          stall_left;
        stall_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                results_seen++;
                if (sorted_expect.size() == 0)
                begin
                    $error("unexpected result: sorted_value %0d end_of_run %0b",
                           sorted_value, end_of_run);
                    fail_count++;
                end
                else
                begin
                    want = sorted_expect.pop_front();
                    if (sorted_value !== want.value)
                    begin
                        $error("sorted_value: expected %0d, got %0d", want.value,
                               sorted_value);
                        fail_count++;
                    end
                    if (end_of_run !== want.last)
                    begin
                        $error("end_of_run: expected %0b, got %0b", want.last, end_of_run);
                        fail_count++;
                    end
                end
            end
            // stall pattern
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // extreme values of the signed range, one set
    task automatic test_extremes();
        send_value(32'h7FFF_FFFF, 1'b0);
        send_value(32'h8000_0000, 1'b0);
        send_value(32'hFFFF_FFFF, 1'b0);
        send_value(32'h0000_0000, 1'b1);
    endtask

    // a set of one value, final on its first transfer
    task automatic test_single_value();
        send_value($urandom, 1'b1);
    endtask

    // equal values in one set
    task automatic test_ties();
        send_value(32'h0002_0000, 1'b0);
        send_value(32'hFFFE_0000, 1'b0);
        send_value(32'h0002_0000, 1'b1);
    endtask

    // fill the store, then a final transfer that is dropped but starts the sort
    task automatic test_store_full();
        for (int i = 0; i < STORE_DEPTH; i++)
            send_value($urandom, 1'b0);
        send_value(32'h7FFF_FFFF, 1'b1);
        wait_drained();
    endtask

    // random sets, mostly well formed, some overfull, some pauses
    task automatic test_random_sets(input int budget);
        int sent;
        int len;
        int flavor;
        int r;
        sent = 0;
        while (sent < budget)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
                len = 1;
            else if (r < 80)
                len = $urandom_range(2, STORE_DEPTH);
            else if (r < 90)
                len = STORE_DEPTH;
            else
                len = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 4);
            flavor = $urandom_range(0, 3);
            if ($urandom_range(0, 7) == 0)
                wait_drained();
            for (int k = 0; k < len; k++)
                send_value(rand_value(flavor), k == len - 1);
            sent += len;
        end
    endtask

    // back-to-back sets with no idling on either side
    task automatic test_back_to_back(input int budget);
        wait_drained();
        quiet = 1'b1;
        test_random_sets(budget);
        wait_drained();
        quiet = 1'b0;
    endtask

    // stimulus sequence
    initial
    begin
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        sample_value <= '0;
        is_final     <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_single_value();
        test_ties();
        test_store_full();
        test_random_sets(260);
        test_back_to_back(80);
        test_random_sets(80);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("run covered %0d value transfers in %0d sorted sets", transfers_in,
                 sets_sorted);
        $display("%0d sorted results checked, %0d mismatches", results_seen, fail_count);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
